// ===== sv/dq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and index helpers for the double-ended queue.
// No dependencies; imported by double_ended_queue.
package dq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // Keep the 32-bit input value in DATA_WIDTH bits (sign-extend or truncate).
    function automatic t_data f_item_in(input logic [31:0] v);
        return DATA_WIDTH'(signed'(v));
    endfunction

    // Present a stored item in 32 bits, sign-extended from DATA_WIDTH.
    function automatic logic [31:0] f_item_out(input t_data d);
        return 32'(signed'(d));
    endfunction

    // Reduce a sum below 2*DEPTH to a ring index.
    function automatic t_addr f_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
        return r[ADDR_W-1:0];
    endfunction

    function automatic t_addr f_inc(input t_addr a);
        return (a == ADDR_W'(DEPTH - 1)) ? '0 : (a + 1'b1);
    endfunction

    function automatic t_addr f_dec(input t_addr a);
        return (a == '0) ? ADDR_W'(DEPTH - 1) : (a - 1'b1);
    endfunction

endpackage

// ===== sv/dq_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== sv/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Double-ended queue top level: ring store in dq_ram, pointers and end cache.
// Depends on dq_pkg and dq_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation per
//   transaction: push front, push back, pop front, pop back, plus a value
//   used only by pushes. Output channel (o_out_valid / i_out_ready) returns
//   exactly one result per operation: popped value, status, item count and
//   the front and back items after the operation (zero when empty).
//   Timing: pushes and rejected operations (pop on empty, push on full)
//   present their result in the cycle after acceptance; a successful pop
//   goes through the read state for a RAM read of the new end item and
//   presents its result once that read returns.
//   Throughput: one push per cycle while results are taken; a successful
//   pop stalls new operations for its RAM read: single read port, registered read.
//   Reset (synchronous, active low) empties the queue: front index and count
//   go to zero. RAM contents are not cleared; unoccupied entries never reach the outputs.
//   A stalled receiver holds the result register; a new operation is taken
//   only in the cycle the held result is taken, so results never drop.
module double_ended_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_operation,
    input  logic [31:0]      i_value,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [31:0]      o_popped_value,
    output dq_pkg::t_status  o_status,
    output logic [6:0]       o_item_count,
    output logic [31:0]      o_front_value,
    output logic [31:0]      o_back_value
);
    import dq_pkg::*;

    // Control state
    t_state  r_state,     n_state;
    logic    r_out_valid, n_out_valid;
    t_addr   r_front_idx, n_front_idx;
    t_cnt    r_count,     n_count;
    logic    r_pop_front, n_pop_front;  // which end the pending read refills

    // Payload: cached end items and result fields
    t_data       r_front_val, n_front_val;
    t_data       r_back_val,  n_back_val;
    logic [31:0] r_popped,    n_popped;
    t_status     r_status,    n_status;

    // RAM port signals
    logic  ram_wr_en;
    t_addr ram_wr_addr;
    t_data ram_wr_data;
    logic  ram_rd_en;
    t_addr ram_rd_addr;
    t_data ram_rd_data;

    logic  in_accept;
    t_op   op;
    t_addr tail_idx;    // slot one past the back item
    t_addr back_idx;    // slot of the back item (valid when non-empty)
    t_data push_val;

    assign op        = t_op'(i_operation);
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_accept = i_in_valid && o_in_ready;
    assign push_val  = f_item_in(i_value);
    assign tail_idx  = f_wrap(SUM_W'(r_front_idx) + SUM_W'(r_count));
    assign back_idx  = f_wrap(SUM_W'(r_front_idx) + SUM_W'(r_count) - 1'b1);

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_front_idx <= '0;
            r_count     <= '0;
            r_pop_front <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_front_idx <= n_front_idx;
            r_count     <= n_count;
            r_pop_front <= n_pop_front;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front_val <= n_front_val;
        r_back_val  <= n_back_val;
        r_popped    <= n_popped;
        r_status    <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_front_idx = r_front_idx;
        n_count     = r_count;
        n_pop_front = r_pop_front;
        n_front_val = r_front_val;
        n_back_val  = r_back_val;
        n_popped    = r_popped;
        n_status    = r_status;
        ram_wr_en   = 1'b0;
        ram_wr_addr = tail_idx;
        ram_wr_data = push_val;
        ram_rd_en   = 1'b0;
        ram_rd_addr = f_inc(r_front_idx);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_popped = '0;
                    n_status = ST_OK;
                    case (op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_wr_en = 1'b1;
                                n_count   = r_count + 1'b1;
                                if (op == OP_PUSH_FRONT) begin
                                    ram_wr_addr = f_dec(r_front_idx);
                                    n_front_idx = f_dec(r_front_idx);
                                    n_front_val = push_val;
                                    if (r_count == '0) begin
                                        n_back_val = push_val;
                                    end
                                end else begin
                                    ram_wr_addr = tail_idx;
                                    n_back_val  = push_val;
                                    if (r_count == '0) begin
                                        n_front_val = push_val;
                                    end
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = ST_EMPTY;
                            end else begin
                                // Result waits for the RAM read of the new end item
                                n_out_valid = 1'b0;
                                n_count     = r_count - 1'b1;
                                ram_rd_en   = 1'b1;
                                n_state     = S_READ;
                                n_pop_front = (op == OP_POP_FRONT);
                                if (op == OP_POP_FRONT) begin
                                    n_popped    = f_item_out(r_front_val);
                                    ram_rd_addr = f_inc(r_front_idx);
                                    n_front_idx = f_inc(r_front_idx);
                                end else begin
                                    n_popped    = f_item_out(r_back_val);
                                    ram_rd_addr = f_dec(back_idx);
                                end
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                // Refill the cached end; stale when the queue went empty,
                // but the outputs show zero then.
                if (r_pop_front) begin
                    n_front_val = ram_rd_data;
                end else begin
                    n_back_val = ram_rd_data;
                end
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result fields come from the state left by the latest operation, which
    // cannot change while a result is held.
    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_item_count   = 7'(r_count);
    assign o_front_value  = (r_count == '0) ? '0 : f_item_out(r_front_val);
    assign o_back_value   = (r_count == '0) ? '0 : f_item_out(r_back_val);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("item count above depth");

    a_read_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (!r_out_valid && !o_in_ready))
        else $error("result or accept during RAM read");

    a_pop_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_operation[1] && (r_count != '0)) |=>
            (r_state == S_READ && r_count == $past(r_count) - 1'b1))
        else $error("pop did not enter read state");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> (r_count == CNT_W'(DEPTH)))
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_EMPTY) |-> (r_count == '0))
        else $error("empty status on non-empty queue");
`endif

endmodule
